>>> src/ssd_pkg.sv
// shared types, codes and the digit image table of the seven-segment scanner
package ssd_pkg;

	localparam int MAX_DIGITS_DEF = 8;
	localparam int DIGITS_RESET = 4;

	localparam int FUNC_W = 3;
	localparam int IDX_W = 3;
	localparam int BCD_W = 4;
	localparam int SEG_W = 8;
	localparam int SEL_W = 3;
	localparam int PERIOD_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [FUNC_W-1:0] FUNC_TICK = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_BCD = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_DOT_SET = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_DOT_CLR = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_DOT_TGL = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_DIGITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_FIRST = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_LAST = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD = 2'd3;

	localparam logic [SEG_W-1:0] DOT_MASK = 8'h80;

	typedef struct packed {
		logic load;
		logic step;
		logic read;
		logic mod_iter;
		logic finish;
	} ssd_cmd_t;

	typedef struct packed {
		logic need_mod;
		logic mod_more;
	} ssd_stat_t;

	function automatic logic [6:0] digit_image(input logic [BCD_W-1:0] bcd);
		logic [6:0] img;
		case (bcd)
			4'd0: img = 7'h3F;
			4'd1: img = 7'h06;
			4'd2: img = 7'h5B;
			4'd3: img = 7'h4F;
			4'd4: img = 7'h66;
			4'd5: img = 7'h6D;
			4'd6: img = 7'h7D;
			4'd7: img = 7'h07;
			4'd8: img = 7'h7F;
			4'd9: img = 7'h6F;
			default: img = 7'h00;
		endcase
		return img;
	endfunction

endpackage

>>> src/ssd_ram.sv
// generic single-port-write ram with registered read
module ssd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/ssd_ctrl.sv
// controller state machine of the seven-segment scanner
module ssd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  ssd_pkg::ssd_stat_t stat,
	output ssd_pkg::ssd_cmd_t  cmd,
	output logic               busy,
	output logic               done
);
	import ssd_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_STEP, S_READ, S_MOD, S_DONE} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == S_DONE);
			case (state_q)
				S_IDLE: if (start) state_q <= S_STEP;
				S_STEP: state_q <= S_READ;
				S_READ: state_q <= stat.need_mod ? S_MOD : S_DONE;
				S_MOD: if (!stat.mod_more) state_q <= S_DONE;
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.load = (state_q == S_IDLE) && start;
		cmd.step = (state_q == S_STEP);
		cmd.read = (state_q == S_READ);
		cmd.mod_iter = (state_q == S_MOD);
		cmd.finish = (state_q == S_DONE);
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	a_accept_steps: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> state_q == S_STEP)
		else $error("accepted item did not enter step");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_mod_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MOD && !stat.mod_more |=> state_q == S_DONE ##1 done)
		else $error("modulo loop did not finish into a result");

endmodule

>>> src/ssd_dp.sv
// datapath of the seven-segment scanner: config, scan pointer, blink counter, segment store
module ssd_dp #(
	parameter int MAX_DIGITS = ssd_pkg::MAX_DIGITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ssd_pkg::ssd_cmd_t                cmd,
	output ssd_pkg::ssd_stat_t               stat,
	input  logic [ssd_pkg::FUNC_W-1:0]       func,
	input  logic [ssd_pkg::IDX_W-1:0]        digit_index,
	input  logic [ssd_pkg::BCD_W-1:0]        bcd_value,
	input  logic                             cfg_we,
	input  logic [ssd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ssd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output logic                             drive_valid,
	output logic [ssd_pkg::SEG_W-1:0]        segments,
	output logic [ssd_pkg::SEL_W-1:0]        digit_select,
	output logic                             dot_on
);
	import ssd_pkg::*;

	localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int DW = $clog2(MAX_DIGITS + 1);
	localparam int CW = 5;
	localparam int SUM_W = PERIOD_W + 1;
	localparam int RST_DIGITS = (DIGITS_RESET > MAX_DIGITS) ? MAX_DIGITS : DIGITS_RESET;
	localparam logic [DW-1:0] DIG_RST = DW'(RST_DIGITS);
	localparam logic [AW-1:0] PTR_RST = AW'(RST_DIGITS - 1);

	// latched item
	logic [FUNC_W-1:0]   func_q;
	logic [IDX_W-1:0]    idx_q;
	logic [BCD_W-1:0]    bcd_q;

	// configuration and scan state
	logic [DW-1:0]       digits_q;
	logic [2:0]          first_q;
	logic [2:0]          last_q;
	logic [PERIOD_W-1:0] period_q;
	logic [PERIOD_W-1:0] counter_q;
	logic [AW-1:0]       ptr_q;
	logic [SUM_W-1:0]    sum_q;
	logic                mod_req_q;
	logic [MAX_DIGITS-1:0] valid_q;
	logic                valid_rd_q;

	// result registers
	logic                drive_valid_q;
	logic [SEG_W-1:0]    segments_q;
	logic [SEL_W-1:0]    digit_select_q;
	logic                dot_on_q;

	logic [DW-1:0]       cfg_digits;
	logic [DW-1:0]       ptr_inc;
	logic [AW-1:0]       ptr_new;
	logic [AW-1:0]       idx_addr;
	logic [AW-1:0]       rd_addr;
	logic [SEG_W-1:0]    ram_rdata;
	logic [SEG_W-1:0]    cur;
	logic                mod_more;
	logic                blank;
	logic                wr_en;
	logic [SEG_W-1:0]    wr_data;
	logic                res_valid;
	logic [SEG_W-1:0]    res_seg;
	logic [SEL_W-1:0]    res_sel;
	logic                res_dot;

	// digit count clamped to 1..MAX_DIGITS
	always_comb begin
		if (cfg_wdata[3:0] == 4'd0) begin
			cfg_digits = DW'(1);
		end else if (CW'(cfg_wdata[3:0]) > CW'(MAX_DIGITS)) begin
			cfg_digits = DW'(MAX_DIGITS);
		end else begin
			cfg_digits = DW'(cfg_wdata[3:0]);
		end
	end

	assign ptr_inc = DW'(ptr_q) + DW'(1);
	assign ptr_new = (ptr_inc == digits_q) ? '0 : AW'(ptr_inc);
	assign idx_addr = AW'(idx_q);
	assign rd_addr = (func_q == FUNC_TICK) ? ptr_q : idx_addr;
	assign mod_more = (sum_q >= SUM_W'(period_q));

	assign stat.need_mod = mod_req_q;
	assign stat.mod_more = mod_more;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			idx_q <= digit_index;
			bcd_q <= bcd_value;
		end
		if (cmd.step) begin
			sum_q <= SUM_W'(counter_q) + SUM_W'(ptr_new == '0 ? digits_q : digits_q);
		end else if (cmd.mod_iter && mod_more) begin
			sum_q <= sum_q - SUM_W'(period_q);
		end
		if (cmd.finish) begin
			drive_valid_q <= res_valid;
			segments_q <= res_seg;
			digit_select_q <= res_sel;
			dot_on_q <= res_dot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digits_q <= DIG_RST;
			first_q <= '0;
			last_q <= '0;
			period_q <= '0;
			counter_q <= '0;
			ptr_q <= PTR_RST;
			mod_req_q <= 1'b0;
			valid_q <= '0;
			valid_rd_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_DIGITS: begin
						digits_q <= cfg_digits;
						ptr_q <= AW'(cfg_digits - DW'(1));
					end
					CFG_BLINK_FIRST: first_q <= cfg_wdata[2:0];
					CFG_BLINK_LAST: last_q <= cfg_wdata[2:0];
					CFG_BLINK_PERIOD: begin
						period_q <= cfg_wdata[PERIOD_W-1:0];
						counter_q <= '0;
					end
					default: ;
				endcase
			end
			if (cmd.step) begin
				if (func_q == FUNC_TICK) begin
					ptr_q <= ptr_new;
				end
				mod_req_q <= (func_q == FUNC_TICK) && (period_q != '0) && (ptr_new == '0);
			end
			if (cmd.mod_iter && !mod_more) begin
				counter_q <= sum_q[PERIOD_W-1:0];
			end
			if (cmd.read) begin
				valid_rd_q <= valid_q[rd_addr];
			end
			if (cmd.finish && wr_en) begin
				valid_q[idx_addr] <= 1'b1;
			end
		end
	end

	// entries never written read as zero
	assign cur = valid_rd_q ? ram_rdata : '0;

	assign blank = (period_q != '0)
		&& (CW'(ptr_q) >= CW'(first_q)) && (CW'(ptr_q) <= CW'(last_q))
		&& (counter_q > (period_q >> 1));

	always_comb begin
		res_valid = 1'b0;
		res_seg = '0;
		res_sel = '0;
		res_dot = 1'b0;
		wr_en = 1'b0;
		wr_data = cur;
		case (func_q)
			FUNC_TICK: begin
				res_valid = 1'b1;
				res_seg = blank ? '0 : cur;
				res_sel = SEL_W'(ptr_q);
			end
			FUNC_BCD: begin
				if (CW'(idx_q) < CW'(digits_q)) begin
					wr_en = 1'b1;
					wr_data = (cur & DOT_MASK) | {1'b0, digit_image(bcd_q)};
				end
			end
			FUNC_DOT_SET, FUNC_DOT_CLR, FUNC_DOT_TGL: begin
				if (CW'(idx_q) < CW'(MAX_DIGITS)) begin
					wr_en = 1'b1;
					if (func_q == FUNC_DOT_SET) begin
						wr_data = cur | DOT_MASK;
					end else if (func_q == FUNC_DOT_CLR) begin
						wr_data = cur & ~DOT_MASK;
					end else begin
						wr_data = cur ^ DOT_MASK;
					end
					res_dot = wr_data[SEG_W-1];
				end
			end
			default: ;
		endcase
	end

	ssd_ram #(
		.WIDTH(SEG_W),
		.DEPTH(MAX_DIGITS)
	) u_seg_ram (
		.clk  (clk),
		.we   (cmd.finish && wr_en),
		.waddr(idx_addr),
		.wdata(wr_data),
		.re   (cmd.read),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	assign drive_valid = drive_valid_q;
	assign segments = segments_q;
	assign digit_select = digit_select_q;
	assign dot_on = dot_on_q;

	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		DW'(ptr_q) < digits_q)
		else $error("scan pointer beyond digit count");

	a_counter_below_period: assert property (@(posedge clk) disable iff (!arst_n)
		period_q != '0 |-> counter_q < period_q)
		else $error("blink counter not reduced below period");

endmodule

>>> src/seven_segment_scan_with_blink.sv
// top level of the multiplexed seven-segment scanner with digit blinking
// an item is taken when start is high and busy low; its result shows on done for one cycle
// an accepted item passes the step, read and done states in turn; when a tick wraps to digit 0
// with blinking on, modulo states subtract the period from counter + digits between read and done
// throughput: a new item may be started in the cycle that done is high
// reset (arst_n low, async): store reads as zero, 4 digits scanned, pointer on last digit
module seven_segment_scan_with_blink #(
	parameter int MAX_DIGITS = ssd_pkg::MAX_DIGITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [ssd_pkg::FUNC_W-1:0]     func,
	input  logic [ssd_pkg::IDX_W-1:0]      digit_index,
	input  logic [ssd_pkg::BCD_W-1:0]      bcd_value,
	input  logic                           cfg_we,
	input  logic [ssd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ssd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output logic                           done,
	output logic                           drive_valid,
	output logic [ssd_pkg::SEG_W-1:0]      segments,
	output logic [ssd_pkg::SEL_W-1:0]      digit_select,
	output logic                           dot_on
);
	import ssd_pkg::*;

	// commands from the sequencer, status back from the datapath
	ssd_cmd_t  cmd;
	ssd_stat_t stat;

	// sequencer: idle, step the pointer, read the store, reduce the blink counter, finish
	ssd_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	// datapath: config registers, scan pointer, blink counter and segment store; config writes land
	// here directly, the user must make them only while idle, and the block itself does not enforce it
	ssd_dp #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.func        (func),
		.digit_index (digit_index),
		.bcd_value   (bcd_value),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.drive_valid (drive_valid),
		.segments    (segments),
		.digit_select(digit_select),
		.dot_on      (dot_on)
	);

endmodule
